@@ src/cnbw_pkg.sv @@
// Package for the character LCD nibble bus writer.
// Holds result record type, state record type, request and result codes.
// No dependencies.
`timescale 1ns / 1ps

package cnbw_pkg;

    // request kinds
    localparam logic [2:0] KIND_CMD_WAIT  = 3'd0;
    localparam logic [2:0] KIND_DATA_WAIT = 3'd1;
    localparam logic [2:0] KIND_DATA_NOW  = 3'd2;
    localparam logic [2:0] KIND_INIT_NIB  = 3'd3;
    localparam logic [2:0] KIND_STATUS    = 3'd4;

    // bus operations
    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // outcomes
    localparam logic [2:0] OC_PENDING = 3'd0;
    localparam logic [2:0] OC_DONE    = 3'd1;
    localparam logic [2:0] OC_DROPPED = 3'd2;
    localparam logic [2:0] OC_LATE    = 3'd3;
    localparam logic [2:0] OC_REJECT  = 3'd4;

    // configuration register indexes
    localparam logic CFG_POLL_LIMIT = 1'b0;
    localparam logic CFG_READBACK   = 1'b1;

    localparam int BUSY_BIT = 7;

    typedef struct packed {
        logic [1:0] bus_op;
        logic       reg_select;
        logic [3:0] nibble;
        logic [2:0] outcome;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       waiting;
        logic [7:0] held_byte;
        logic       held_is_data;
        logic [7:0] polls_left;
    } state_t;

    function automatic result_t mk_result(logic [1:0] op, logic rs, logic [3:0] nib,
                                          logic [2:0] oc, logic last);
        result_t r;
        r.bus_op     = op;
        r.reg_select = rs;
        r.nibble     = nib;
        r.outcome    = oc;
        r.last       = last;
        return r;
    endfunction

endpackage

@@ src/cnbw_req_if.sv @@
// Request channel of the LCD nibble bus writer: kind and value.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps

interface cnbw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

@@ src/cnbw_res_if.sv @@
// Result channel of the LCD nibble bus writer: one bus action per transfer.
// Standalone interface, no package dependency.
`timescale 1ns / 1ps

interface cnbw_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] bus_op;
    logic       reg_select;
    logic [3:0] nibble;
    logic [2:0] outcome;
    logic       last;

    modport source (output valid, output bus_op, output reg_select, output nibble,
                    output outcome, output last, input ready);
    modport sink   (input valid, input bus_op, input reg_select, input nibble,
                    input outcome, input last, output ready);
endinterface

@@ src/cnbw_step.sv @@
// Request decoder: next wait state and up to two bus results for one request.
// Depends on cnbw_pkg.
`timescale 1ns / 1ps

module cnbw_step (
    input  logic [2:0]       kind,
    input  logic [7:0]       value,
    input  cnbw_pkg::state_t state,
    input  logic [7:0]       poll_limit,
    input  logic             readback_enable,
    output cnbw_pkg::state_t state_next,
    output logic             two_results,
    output cnbw_pkg::result_t res0,
    output cnbw_pkg::result_t res1
);
    import cnbw_pkg::*;

    always_comb
    begin
        state_next  = state;
        two_results = 1'b0;
        res0        = mk_result(OP_REPORT, 1'b0, 4'd0, OC_REJECT, 1'b1);
        res1        = mk_result(OP_WRITE, 1'b0, 4'd0, OC_DONE, 1'b1);

        if (kind == KIND_STATUS)
        begin
            priority if (!state.waiting)
            begin
                // stray status reply, keep state
            end
            else if (!value[BUSY_BIT])
            begin
                state_next.waiting = 1'b0;
                two_results = 1'b1;
                res0 = mk_result(OP_WRITE, state.held_is_data, state.held_byte[7:4],
                                 OC_PENDING, 1'b0);
                res1 = mk_result(OP_WRITE, state.held_is_data, state.held_byte[3:0],
                                 OC_DONE, 1'b1);
            end
            else if (state.polls_left <= 8'd1)
            begin
                // budget spent: data goes out anyway, commands are dropped
                state_next.waiting    = 1'b0;
                state_next.polls_left = 8'd0;
                if (state.held_is_data)
                begin
                    two_results = 1'b1;
                    res0 = mk_result(OP_WRITE, 1'b1, state.held_byte[7:4], OC_PENDING, 1'b0);
                    res1 = mk_result(OP_WRITE, 1'b1, state.held_byte[3:0], OC_LATE, 1'b1);
                end
                else
                begin
                    res0 = mk_result(OP_REPORT, 1'b0, 4'd0, OC_DROPPED, 1'b1);
                end
            end
            else
            begin
                state_next.polls_left = state.polls_left - 8'd1;
                res0 = mk_result(OP_STATUS, 1'b0, 4'd0, OC_PENDING, 1'b1);
            end
        end
        else if (!state.waiting)
        begin
            unique case (kind)
                KIND_CMD_WAIT, KIND_DATA_WAIT:
                begin
                    if (!readback_enable)
                    begin
                        two_results = 1'b1;
                        res0 = mk_result(OP_WRITE, kind[0], value[7:4], OC_PENDING, 1'b0);
                        res1 = mk_result(OP_WRITE, kind[0], value[3:0], OC_DONE, 1'b1);
                    end
                    else
                    begin
                        state_next.waiting      = 1'b1;
                        state_next.held_byte    = value;
                        state_next.held_is_data = kind[0];
                        state_next.polls_left   = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
                        res0 = mk_result(OP_STATUS, 1'b0, 4'd0, OC_PENDING, 1'b1);
                    end
                end
                KIND_DATA_NOW:
                begin
                    two_results = 1'b1;
                    res0 = mk_result(OP_WRITE, 1'b1, value[7:4], OC_PENDING, 1'b0);
                    res1 = mk_result(OP_WRITE, 1'b1, value[3:0], OC_DONE, 1'b1);
                end
                KIND_INIT_NIB:
                begin
                    res0 = mk_result(OP_WRITE, 1'b0, value[3:0], OC_DONE, 1'b1);
                end
                default:
                begin
                    // unknown kinds are rejected
                end
            endcase
        end
    end

endmodule

@@ src/char_lcd_nibble_bus_writer_core.sv @@
// Top level of the character LCD nibble bus writer.
// Depends on cnbw_pkg, cnbw_req_if, cnbw_res_if and cnbw_step.
`timescale 1ns / 1ps

// Turns LCD requests into 4-bit bus actions. A request is decoded in the cycle
// it is accepted; its one or two results enter a four-entry result queue, and
// the queue hands out one result per cycle while res.ready is high. A request
// is taken whenever the queue has room for two results, so requests giving
// one result run at one per cycle while results are taken; byte writes are
// held back by the single result port. Waited requests (readback on) issue a
// status read, consuming status replies as later requests until busy clears
// or poll_limit replies are spent. Config writes apply from the next request.
module char_lcd_nibble_bus_writer_core (
    input  logic       clk,
    input  logic       rst_n,
    cnbw_req_if.sink   req,
    cnbw_res_if.source res,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import cnbw_pkg::*;

    logic [7:0] poll_limit_reg;
    logic       readback_enable_reg;
    state_t     state_reg;
    state_t     state_next;

    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    logic       push;
    logic       pop;
    logic       two_results;
    result_t    res0;
    result_t    res1;
    result_t    head;

    cnbw_step u_step (
        .kind            (req.kind),
        .value           (req.value),
        .state           (state_reg),
        .poll_limit      (poll_limit_reg),
        .readback_enable (readback_enable_reg),
        .state_next      (state_next),
        .two_results     (two_results),
        .res0            (res0),
        .res1            (res1)
    );

    assign req.ready = (count_reg <= 3'd2);
    assign push      = req.valid && req.ready;
    assign pop       = res.valid && res.ready;

    assign head           = queue_reg[rd_ptr_reg];
    assign res.valid      = (count_reg != 3'd0);
    assign res.bus_op     = head.bus_op;
    assign res.reg_select = head.reg_select;
    assign res.nibble     = head.nibble;
    assign res.outcome    = head.outcome;
    assign res.last       = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + {1'b0, two_results} + 2'd1;
            count_next  = count_next + {2'b00, two_results} + 3'd1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
            count_next  = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg      <= 8'd254;
            readback_enable_reg <= 1'b1;
            state_reg           <= '0;
            wr_ptr_reg          <= 2'd0;
            rd_ptr_reg          <= 2'd0;
            count_reg           <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POLL_LIMIT: poll_limit_reg      <= cfg_data;
                    CFG_READBACK:   readback_enable_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (push)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= res0;
            if (two_results)
            begin
                queue_reg[wr_ptr_reg + 2'd1] <= res1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_polls_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.waiting |-> (state_reg.polls_left != 8'd0))
        else $error("waiting with empty poll budget");

    a_wait_needs_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.waiting) |-> $past(readback_enable_reg))
        else $error("wait started with readback disabled");

    a_first_half_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> (res.bus_op == OP_WRITE && count_reg >= 3'd2))
        else $error("high nibble without its low nibble queued");

endmodule
